// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
// both expect clk_i and rst_ni in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, consequent may start with a fixed delay
`define KVI_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KVI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kvi_pkg.sv =====
`timescale 1ns / 1ps
package kvi_pkg;

  typedef enum logic [1:0] {
    FUNC_LINEAR = 2'd0,
    FUNC_COSINE = 2'd1,
    FUNC_BEZIER = 2'd2,
    FUNC_ARGB   = 2'd3
  } func_e;

  typedef struct packed {
    logic  valid;
    func_e func;
  } ctl_t;

  localparam logic [31:0] ARGB_MASK_RB = 32'h00ff00ff;
  localparam logic [31:0] ARGB_MASK_AG = 32'hff00ff00;
  localparam int unsigned ARGB_W_BITS  = 9;

  // pi in Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int unsigned TAYLOR_TERMS = 12;
  // (2k)(2k+1) for k = 1 .. 12
  localparam logic [15:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
    16'd6, 16'd20, 16'd42, 16'd72, 16'd110, 16'd156,
    16'd210, 16'd272, 16'd342, 16'd420, 16'd506, 16'd600
  };

  // cosine ease weight (1 - cos(pi m)) / 2 = sin^2(pi m / 2), elaboration only
  function automatic logic [31:0] cos_weight(input int unsigned idx,
                                             input int unsigned frac_bits,
                                             input int unsigned tbl_bits);
    logic [63:0]        y;
    logic [63:0]        y2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        su;
    logic [63:0]        w;
    logic [63:0]        one;
    y  = (PI_Q30 * 64'(idx) + (64'd1 << tbl_bits)) >> (tbl_bits + 1);
    y2 = (y * y) >> 30;
    t  = y;
    s  = signed'(y);
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      t = ((t * y2) >> 30) / 64'(TAYLOR_DEN[k]);
      if ((k % 2) == 0) begin
        s = s - signed'(t);
      end else begin
        s = s + signed'(t);
      end
    end
    if (s < 0) begin
      s = '0;
    end
    if (s > (64'sd1 <<< 30)) begin
      s = 64'sd1 <<< 30;
    end
    su  = unsigned'(s);
    w   = (su * su + (64'd1 << (59 - frac_bits))) >> (60 - frac_bits);
    one = 64'd1 << frac_bits;
    if (w > one) begin
      w = one;
    end
    return w[31:0];
  endfunction

endpackage

// ===== src/kvi_prep.sv =====
`timescale 1ns / 1ps
module kvi_prep #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [1:0]                           func_i,
  input  logic [FRAC_BITS:0]                   position_i,
  input  logic [31:0]                          a_i,
  input  logic [31:0]                          b_i,
  input  logic [31:0]                          c_i,
  output kvi_pkg::ctl_t                        ctl_o,
  output logic [FRAC_BITS:0]                   pos_o,
  output logic [COS_TABLE_BITS:0]              idx_o,
  output logic [kvi_pkg::ARGB_W_BITS-1:0]      argb_w_o,
  output logic [31:0]                          a_o,
  output logic [31:0]                          b_o,
  output logic [31:0]                          c_o
);

  localparam int unsigned IdxW = FRAC_BITS + COS_TABLE_BITS + 2;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IdxW-1:0] HalfOne =
    {{(IdxW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  logic [FRAC_BITS:0]                  pos_sat;
  logic [IdxW-1:0]                     idx_sum;
  logic [kvi_pkg::ARGB_W_BITS-1:0]     argb_w;

  kvi_pkg::ctl_t                       ctl_q;
  logic [FRAC_BITS:0]                  pos_q;
  logic [COS_TABLE_BITS:0]             idx_q;
  logic [kvi_pkg::ARGB_W_BITS-1:0]     argb_w_q;
  logic [31:0]                         a_q;
  logic [31:0]                         b_q;
  logic [31:0]                         c_q;

  // positions past one saturate to one
  assign pos_sat = (position_i > One) ? One : position_i;

  // table index, m rounded to the table grid
  assign idx_sum = ({{(COS_TABLE_BITS + 1){1'b0}}, pos_sat} << COS_TABLE_BITS) + HalfOne;

  // argb weight round(256 m), ties to even
  if (FRAC_BITS == 8) begin : g_w_direct
    assign argb_w = pos_sat;
  end else begin : g_w_round
    localparam int unsigned Sh = FRAC_BITS - 8;
    localparam logic [Sh-1:0] Half = Sh'(1) << (Sh - 1);
    logic [kvi_pkg::ARGB_W_BITS-1:0] w_trunc;
    logic [Sh-1:0]                   w_rem;
    logic                            round_up;
    assign w_trunc  = pos_sat[FRAC_BITS -: kvi_pkg::ARGB_W_BITS];
    assign w_rem    = pos_sat[Sh-1:0];
    assign round_up = (w_rem > Half) || ((w_rem == Half) && w_trunc[0]);
    assign argb_w   = w_trunc + kvi_pkg::ARGB_W_BITS'(round_up);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= accept_i;
      ctl_q.func  <= kvi_pkg::func_e'(func_i);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_sat;
    idx_q    <= idx_sum[FRAC_BITS +: COS_TABLE_BITS + 1];
    argb_w_q <= argb_w;
    a_q      <= a_i;
    b_q      <= b_i;
    c_q      <= c_i;
  end

  assign ctl_o    = ctl_q;
  assign pos_o    = pos_q;
  assign idx_o    = idx_q;
  assign argb_w_o = argb_w_q;
  assign a_o      = a_q;
  assign b_o      = b_q;
  assign c_o      = c_q;

endmodule

// ===== src/kvi_cos_rom.sv =====
`timescale 1ns / 1ps
module kvi_cos_rom #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic [COS_TABLE_BITS:0] rd_idx_i,
  output logic [FRAC_BITS:0]      rd_data_o
);

  localparam int unsigned Entries = (1 << COS_TABLE_BITS) + 1;

  typedef logic [FRAC_BITS:0] rom_t [Entries];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < Entries; i++) begin
      r[i] = (FRAC_BITS + 1)'(kvi_pkg::cos_weight(i, FRAC_BITS, COS_TABLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t RomData = build_rom();

  logic [FRAC_BITS:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= RomData[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/kvi_square.sv =====
`timescale 1ns / 1ps
module kvi_square #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kvi_pkg::ctl_t                    ctl_i,
  input  logic [FRAC_BITS:0]               pos_i,
  input  logic [kvi_pkg::ARGB_W_BITS-1:0]  argb_w_i,
  input  logic [31:0]                      a_i,
  input  logic [31:0]                      b_i,
  input  logic [31:0]                      c_i,
  output kvi_pkg::ctl_t                    ctl_o,
  output logic [FRAC_BITS:0]               pos_o,
  output logic [kvi_pkg::ARGB_W_BITS-1:0]  argb_w_o,
  output logic [31:0]                      a_o,
  output logic [31:0]                      b_o,
  output logic [31:0]                      c_o,
  output logic [2*FRAC_BITS:0]             qq_o,
  output logic [2*FRAC_BITS:0]             pq2_o,
  output logic [2*FRAC_BITS:0]             pp_o
);

  localparam int unsigned PrdW = 2 * FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]              q;
  logic [PrdW-1:0]                 qq_full;
  logic [PrdW-1:0]                 pq_full;
  logic [PrdW-1:0]                 pp_full;

  kvi_pkg::ctl_t                   ctl_q;
  logic [FRAC_BITS:0]              pos_q;
  logic [kvi_pkg::ARGB_W_BITS-1:0] argb_w_q;
  logic [31:0]                     a_q;
  logic [31:0]                     b_q;
  logic [31:0]                     c_q;
  logic [2*FRAC_BITS:0]            qq_q;
  logic [2*FRAC_BITS:0]            pq2_q;
  logic [2*FRAC_BITS:0]            pp_q;

  // bezier basis terms (1-m)^2, 2m(1-m), m^2
  assign q       = One - pos_i;
  assign qq_full = PrdW'(q) * PrdW'(q);
  assign pq_full = (PrdW'(pos_i) * PrdW'(q)) << 1;
  assign pp_full = PrdW'(pos_i) * PrdW'(pos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_i;
    argb_w_q <= argb_w_i;
    a_q      <= a_i;
    b_q      <= b_i;
    c_q      <= c_i;
    qq_q     <= qq_full[2*FRAC_BITS:0];
    pq2_q    <= pq_full[2*FRAC_BITS:0];
    pp_q     <= pp_full[2*FRAC_BITS:0];
  end

  assign ctl_o    = ctl_q;
  assign pos_o    = pos_q;
  assign argb_w_o = argb_w_q;
  assign a_o      = a_q;
  assign b_o      = b_q;
  assign c_o      = c_q;
  assign qq_o     = qq_q;
  assign pq2_o    = pq2_q;
  assign pp_o     = pp_q;

endmodule

// ===== src/kvi_blend.sv =====
`timescale 1ns / 1ps
module kvi_blend #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kvi_pkg::ctl_t                    ctl_i,
  input  logic [FRAC_BITS:0]               pos_i,
  input  logic [FRAC_BITS:0]               rom_w_i,
  input  logic [kvi_pkg::ARGB_W_BITS-1:0]  argb_w_i,
  input  logic [31:0]                      a_i,
  input  logic [31:0]                      b_i,
  input  logic [31:0]                      c_i,
  input  logic [2*FRAC_BITS:0]             qq_i,
  input  logic [2*FRAC_BITS:0]             pq2_i,
  input  logic [2*FRAC_BITS:0]             pp_i,
  output logic                             valid_o,
  output logic [31:0]                      result_o
);

  localparam int unsigned XW = 2 * FRAC_BITS + 1;
  localparam int unsigned PW = 32 + XW;
  localparam int unsigned SW = PW + 2;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] LinBias = {{(SW - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // multiply stage
  logic [FRAC_BITS:0] w;
  logic               is_bez;
  logic [XW-1:0]      x0;
  logic [XW-1:0]      x1;
  logic [XW-1:0]      x2;
  logic [31:0]        d_ag;
  logic [31:0]        d_rb;

  kvi_pkg::ctl_t      ctl3_q;
  logic [PW-1:0]      p0_q;
  logic [PW-1:0]      p1_q;
  logic [PW-1:0]      p2_q;
  logic [31:0]        ag_mul_q;
  logic [31:0]        rb_mul_q;
  logic [31:0]        a3_q;

  // sum stage
  logic [SW-1:0]      bias;
  logic [SW-1:0]      sum;
  logic [31:0]        ag;
  logic [31:0]        rb;
  logic [31:0]        res_d;

  logic               valid_q;
  logic [31:0]        result_q;

  assign is_bez = (ctl_i.func == kvi_pkg::FUNC_BEZIER);
  assign w      = (ctl_i.func == kvi_pkg::FUNC_COSINE) ? rom_w_i : pos_i;

  // one multiplier set serves the linear and cosine blends and the bezier
  assign x0 = is_bez ? qq_i  : XW'(One - w);
  assign x1 = is_bez ? pp_i  : XW'(w);
  assign x2 = is_bez ? pq2_i : '0;

  // split channel differences, borrows wrap
  assign d_ag = ((b_i >> 8) & kvi_pkg::ARGB_MASK_RB) - ((a_i >> 8) & kvi_pkg::ARGB_MASK_RB);
  assign d_rb = (b_i & kvi_pkg::ARGB_MASK_RB) - (a_i & kvi_pkg::ARGB_MASK_RB);

  always_ff @(posedge clk_i) begin
    p0_q     <= PW'(a_i) * PW'(x0);
    p1_q     <= PW'(b_i) * PW'(x1);
    p2_q     <= PW'(c_i) * PW'(x2);
    ag_mul_q <= d_ag * 32'(argb_w_i);
    rb_mul_q <= d_rb * 32'(argb_w_i);
    a3_q     <= a_i;
  end

  // ceiling bias for the integer blends, bezier truncates
  assign bias = (ctl3_q.func == kvi_pkg::FUNC_BEZIER) ? SW'(p2_q) : LinBias;
  assign sum  = SW'(p0_q) + SW'(p1_q) + bias;

  assign ag = (ag_mul_q + (a3_q & kvi_pkg::ARGB_MASK_AG)) & kvi_pkg::ARGB_MASK_AG;
  assign rb = ((rb_mul_q >> 8) + (a3_q & kvi_pkg::ARGB_MASK_RB)) & kvi_pkg::ARGB_MASK_RB;

  always_comb begin
    case (ctl3_q.func)
      kvi_pkg::FUNC_LINEAR: res_d = sum[FRAC_BITS +: 32];
      kvi_pkg::FUNC_COSINE: res_d = sum[FRAC_BITS +: 32];
      kvi_pkg::FUNC_BEZIER: res_d = sum[2*FRAC_BITS +: 32];
      kvi_pkg::FUNC_ARGB:   res_d = ag + rb;
      default:              res_d = sum[FRAC_BITS +: 32];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      ctl3_q  <= ctl_i;
      valid_q <= ctl3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== src/keyframe_value_interpolator_top.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+----------------------------------------
// request   | in        | start_i high, busy_o low | func_i, position_i, start_value_i,
//           |           |                        | end_value_i, control_point_i
// result    | out       | valid_o one-cycle strobe | result_o
//
// one request per cycle while busy_o is low; results leave in the order their requests were taken
// the four register stages (prep, basis squares with cosine rom read, multiply,
// final sum) set the latency; the multiply stage is the deepest logic
// rst_ni is asynchronous, active low, and clears every stage valid bit
// busy_o is registered: high in reset, and low once a clock edge has seen rst_ni released
// the result side cannot stall, so busy_o stays low from then on
module keyframe_value_interpolator_top #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           func_i,
  input  logic [FRAC_BITS:0]   position_i,
  input  logic [31:0]          start_value_i,
  input  logic [31:0]          end_value_i,
  input  logic [31:0]          control_point_i,
  output logic                 valid_o,
  output logic [31:0]          result_o
);

  logic                            busy_q;
  logic                            accept;

  // stage 1 outputs
  kvi_pkg::ctl_t                   s1_ctl;
  logic [FRAC_BITS:0]              s1_pos;
  logic [COS_TABLE_BITS:0]         s1_idx;
  logic [kvi_pkg::ARGB_W_BITS-1:0] s1_argb_w;
  logic [31:0]                     s1_a;
  logic [31:0]                     s1_b;
  logic [31:0]                     s1_c;

  // stage 2 outputs
  kvi_pkg::ctl_t                   s2_ctl;
  logic [FRAC_BITS:0]              s2_pos;
  logic [FRAC_BITS:0]              s2_rom_w;
  logic [kvi_pkg::ARGB_W_BITS-1:0] s2_argb_w;
  logic [31:0]                     s2_a;
  logic [31:0]                     s2_b;
  logic [31:0]                     s2_c;
  logic [2*FRAC_BITS:0]            s2_qq;
  logic [2*FRAC_BITS:0]            s2_pq2;
  logic [2*FRAC_BITS:0]            s2_pp;

  // hold off requests only while in reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // stage 1: saturate position, table index, argb weight
  kvi_prep #(
    .FRAC_BITS      (FRAC_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .position_i (position_i),
    .a_i        (start_value_i),
    .b_i        (end_value_i),
    .c_i        (control_point_i),
    .ctl_o      (s1_ctl),
    .pos_o      (s1_pos),
    .idx_o      (s1_idx),
    .argb_w_o   (s1_argb_w),
    .a_o        (s1_a),
    .b_o        (s1_b),
    .c_o        (s1_c)
  );

  // stage 2: cosine weight lookup, lines up with the square stage
  kvi_cos_rom #(
    .FRAC_BITS      (FRAC_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_cos_rom (
    .clk_i     (clk_i),
    .rd_idx_i  (s1_idx),
    .rd_data_o (s2_rom_w)
  );

  // stage 2: bezier basis squares
  kvi_square #(
    .FRAC_BITS (FRAC_BITS)
  ) u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s1_ctl),
    .pos_i    (s1_pos),
    .argb_w_i (s1_argb_w),
    .a_i      (s1_a),
    .b_i      (s1_b),
    .c_i      (s1_c),
    .ctl_o    (s2_ctl),
    .pos_o    (s2_pos),
    .argb_w_o (s2_argb_w),
    .a_o      (s2_a),
    .b_o      (s2_b),
    .c_o      (s2_c),
    .qq_o     (s2_qq),
    .pq2_o    (s2_pq2),
    .pp_o     (s2_pp)
  );

  // stages 3 and 4: weighted products, then sum, round and select
  kvi_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s2_ctl),
    .pos_i    (s2_pos),
    .rom_w_i  (s2_rom_w),
    .argb_w_i (s2_argb_w),
    .a_i      (s2_a),
    .b_i      (s2_b),
    .c_i      (s2_c),
    .qq_i     (s2_qq),
    .pq2_i    (s2_pq2),
    .pp_i     (s2_pp),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

// ===== src/kvi_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kvi_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [1:0]         func_i,
  input logic [FRAC_BITS:0] position_i,
  input logic [31:0]        start_value_i,
  input logic [31:0]        end_value_i,
  input logic               valid_o,
  input logic [31:0]        result_o
);

  logic req;

  assign req = start_i && !busy_o;

  // every taken request gives a result strobe, and every strobe has a taken request behind it
  `KVI_ASSERT_NEXT(a_req_gives_result, req, ##3 valid_o, "request gave no result strobe")
  `KVI_ASSERT_IMPLIES(a_result_has_req, valid_o, $past(req, 4), "result strobe without request")

  // linear blend at position zero returns the start value
  `KVI_ASSERT_IMPLIES(a_linear_zero, req && (func_i == kvi_pkg::FUNC_LINEAR) && (position_i == '0), ##4 (result_o == $past(start_value_i, 4)), "linear blend at zero lost start")

  // argb blend between equal endpoints is the identity
  `KVI_ASSERT_IMPLIES(a_argb_equal, req && (func_i == kvi_pkg::FUNC_ARGB) && (start_value_i == end_value_i), ##4 (result_o == $past(start_value_i, 4)), "argb blend of equal ends changed")

endmodule

bind keyframe_value_interpolator_top kvi_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_kvi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .func_i        (func_i),
  .position_i    (position_i),
  .start_value_i (start_value_i),
  .end_value_i   (end_value_i),
  .valid_o       (valid_o),
  .result_o      (result_o)
);

// ===== tb/tb_keyframe_value_interpolator_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the keyframe value interpolator
// requests go in through start_i / busy_o, results come back on a valid_o strobe
// every taken request is scored against its typed-in result or a local model of the four blend kinds
module tb_keyframe_value_interpolator_top;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned TBL_BITS   = 10;
  localparam logic [63:0] ONE        = 64'd1 << FRAC;
  localparam int unsigned ROM_SIZE   = (1 << TBL_BITS) + 1;
  localparam int unsigned N_DIRECTED = 26;
  localparam int unsigned RAND_ITEMS = 1625;
  // last stretch of requests goes back to back
  localparam int unsigned NO_GAP_TAIL = 200;
  // longest honest quiet spell is a gap burst plus the pipe depth
  localparam int unsigned WATCHDOG_LIMIT = 200;
  localparam int unsigned MAX_REPORTS    = 10;

  // short names for the blend kinds, keeps the table readable
  localparam kvi_pkg::func_e K_LIN  = kvi_pkg::FUNC_LINEAR;
  localparam kvi_pkg::func_e K_COS  = kvi_pkg::FUNC_COSINE;
  localparam kvi_pkg::func_e K_BEZ  = kvi_pkg::FUNC_BEZIER;
  localparam kvi_pkg::func_e K_ARGB = kvi_pkg::FUNC_ARGB;

  // one row of the directed table; want is typed in only where it is obvious
  typedef struct packed {
    kvi_pkg::func_e kind;
    logic [16:0]    pos;
    logic [31:0]    start_v;
    logic [31:0]    end_v;
    logic [31:0]    ctrl;
    logic           has_want;
    logic [31:0]    want;
  } stim_row_t;

  // what a taken request should produce, kept with its request for messages
  typedef struct {
    kvi_pkg::func_e kind;
    logic [16:0]    pos;
    logic [31:0]    want;
  } due_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [16:0] position_i;
  logic [31:0] start_value_i;
  logic [31:0] end_value_i;
  logic [31:0] control_point_i;
  logic        valid_o;
  logic [31:0] result_o;

  // typed-in expectation that rides along with the request on the bus
  logic        req_has_want;
  logic [31:0] req_want;

  logic [31:0] ease_weight_rom [ROM_SIZE];
  due_result_t pending_results [$];
  int unsigned results_due = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  stim_row_t   directed_rows [N_DIRECTED];

  keyframe_value_interpolator_top #(
    .FRAC_BITS      (FRAC),
    .COS_TABLE_BITS (TBL_BITS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .position_i      (position_i),
    .start_value_i   (start_value_i),
    .end_value_i     (end_value_i),
    .control_point_i (control_point_i),
    .valid_o         (valid_o),
    .result_o        (result_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // local model of the blend kinds
  // ---------------------------------------------------------------------------

  // sin^2(pi i / 2^(tbl+1)) in q16, from a fixed-point taylor series of sin
  function automatic logic [31:0] ease_weight(input int unsigned i);
    logic [63:0]        y;
    logic [63:0]        y2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        w;
    y  = (kvi_pkg::PI_Q30 * 64'(i) + (64'd1 << TBL_BITS)) >> (TBL_BITS + 1);
    y2 = (y * y) >> 30;
    t  = y;
    s  = signed'(y);
    for (int unsigned k = 1; k <= 12; k++) begin
      t = ((t * y2) >> 30) / 64'((2 * k) * (2 * k + 1));
      // odd terms subtract, even terms add
      if (k % 2 == 1) begin
        s = s - signed'(t);
      end else begin
        s = s + signed'(t);
      end
    end
    if (s < 0) begin
      s = '0;
    end
    if (s > (64'sd1 <<< 30)) begin
      s = 64'sd1 <<< 30;
    end
    // round half up from q60 down to q16
    w = (unsigned'(s) * unsigned'(s) + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    if (w > ONE) begin
      w = ONE;
    end
    return w[31:0];
  endfunction

  // (a (one - w) + b w) / one, rounded up
  function automatic logic [31:0] ceil_mix(input logic [31:0] a, input logic [31:0] b,
                                           input logic [63:0] w);
    logic [63:0] num;
    num = {32'd0, a} * (ONE - w) + {32'd0, b} * w;
    num = (num + ONE - 64'd1) >> FRAC;
    return num[31:0];
  endfunction

  function automatic logic [31:0] interp_value(input kvi_pkg::func_e kind,
                                               input logic [16:0] pos,
                                               input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
    logic [63:0]  p;
    logic [63:0]  idx;
    logic [127:0] pw;
    logic [127:0] qw;
    logic [127:0] acc;
    logic [63:0]  qv;
    logic [31:0]  r;
    logic [31:0]  ag;
    logic [31:0]  rb_prod;
    logic [31:0]  rb;
    p = 64'(pos);
    // positions past one stick at one
    if (p > ONE) begin
      p = ONE;
    end
    case (kind)
      kvi_pkg::FUNC_LINEAR: begin
        if (a == b) begin
          return a;
        end
        return ceil_mix(a, b, p);
      end
      kvi_pkg::FUNC_COSINE: begin
        idx = ((p << TBL_BITS) + (ONE >> 1)) >> FRAC;
        if (idx >= ROM_SIZE) begin
          idx = ROM_SIZE - 1;
        end
        return ceil_mix(a, b, 64'(ease_weight_rom[idx]));
      end
      kvi_pkg::FUNC_BEZIER: begin
        pw  = 128'(p);
        qw  = 128'(ONE - p);
        acc = qw * qw * a + 2 * pw * qw * c + pw * pw * b;
        return acc[63:32];
      end
      default: begin
        if (a == b) begin
          return a;
        end
        // 9-bit weight from m, ties to even
        qv = p >> (FRAC - 8);
        if (p[7:0] > 8'h80 || (p[7:0] == 8'h80 && qv[0])) begin
          qv = qv + 64'd1;
        end
        r  = qv[31:0];
        // channel differences wrap on borrow, kept as they are
        ag = ((((b >> 8) & kvi_pkg::ARGB_MASK_RB) - ((a >> 8) & kvi_pkg::ARGB_MASK_RB)) * r
              + (a & kvi_pkg::ARGB_MASK_AG)) & kvi_pkg::ARGB_MASK_AG;
        rb_prod = ((b & kvi_pkg::ARGB_MASK_RB) - (a & kvi_pkg::ARGB_MASK_RB)) * r;
        rb = ((rb_prod >> 8) + (a & kvi_pkg::ARGB_MASK_RB)) & kvi_pkg::ARGB_MASK_RB;
        return ag + rb;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'($urandom_range(0, 255));
      3:       return {8'($urandom_range(0, 255)), 24'h0} | 32'h00ff_00ff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [16:0] pick_position();
    logic [7:0] hi_part;
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'(ONE);
      // above one, any pattern of the spare bits
      2:       return 17'($urandom_range(32'h0001_0001, 32'h0001_ffff));
      // exactly half way between two argb weights
      3: begin
        hi_part = 8'($urandom_range(0, 255));
        return {1'b0, hi_part, 8'h80};
      end
      4:       return 17'($urandom_range(0, 255));
      default: return 17'($urandom_range(0, 32'h0001_0000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // hold a request on the bus until it is taken at an edge with busy_o low
  task automatic send_request(input kvi_pkg::func_e kind, input logic [16:0] pos,
                              input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic has_want,
                              input logic [31:0] want);
    start_i         <= 1'b1;
    func_i          <= kind;
    position_i      <= pos;
    start_value_i   <= a;
    end_value_i     <= b;
    control_point_i <= c;
    req_has_want    <= has_want;
    req_want        <= want;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // sender goes quiet, with junk on the payload that must be ignored
  task automatic idle_burst(input int unsigned cycles);
    start_i         <= 1'b0;
    func_i          <= 2'($urandom());
    position_i      <= 17'($urandom());
    start_value_i   <= $urandom();
    end_value_i     <= $urandom();
    control_point_i <= $urandom();
    req_has_want    <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_for_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: score strobes, record taken requests, feed the watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    due_result_t due;
    logic        took_req;
    logic        got_res;
    took_req = 1'b0;
    got_res  = 1'b0;
    if (rst_ni === 1'b1) begin
      if (valid_o === 1'b1) begin
        got_res = 1'b1;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result %h at %0t", result_o, $realtime);
          end
        end else begin
          due = pending_results.pop_front();
          if (result_o !== due.want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("result mismatch kind %s pos %h: expected %h, got %h",
                       due.kind.name(), due.pos, due.want, result_o);
            end
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        took_req  = 1'b1;
        due.kind  = kvi_pkg::func_e'(func_i);
        due.pos   = position_i;
        due.want  = req_has_want ? req_want
                  : interp_value(kvi_pkg::func_e'(func_i), position_i, start_value_i,
                                 end_value_i, control_point_i);
        pending_results.push_back(due);
      end
    end
    results_due <= results_due + took_req - (got_res && results_due != 0);
    idle_cycles <= (took_req || got_res) ? 0 : idle_cycles + 1;
  end

  // watchdog: too long without a request taken or a result seen
  initial begin
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("watchdog expired after %0d quiet cycles", idle_cycles);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    kvi_pkg::func_e kind;
    logic [31:0]    a;
    logic [31:0]    b;
    logic           gappy;

    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    func_i          <= '0;
    position_i      <= '0;
    start_value_i   <= '0;
    end_value_i     <= '0;
    control_point_i <= '0;
    req_has_want    <= 1'b0;
    req_want        <= '0;

    for (int unsigned i = 0; i < ROM_SIZE; i++) begin
      ease_weight_rom[i] = ease_weight(i);
    end

    // kind, position, start, end, control, typed?, typed result
    directed_rows = '{
      // linear: both ends, saturated position, equal ends, mid and tiny steps
      '{K_LIN,  17'h00000, 32'h12345678, 32'h9abcdef0, 32'h00000000, 1'b1, 32'h12345678},
      '{K_LIN,  17'h10000, 32'h12345678, 32'h9abcdef0, 32'h00000000, 1'b1, 32'h9abcdef0},
      '{K_LIN,  17'h1ffff, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff},
      '{K_LIN,  17'h08000, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b0, 32'h0},
      '{K_LIN,  17'h04321, 32'hdeadbeef, 32'hdeadbeef, 32'h00000000, 1'b1, 32'hdeadbeef},
      '{K_LIN,  17'h00001, 32'hffffffff, 32'h00000000, 32'hffffffff, 1'b0, 32'h0},
      // cosine: zero weight at m = 0, rom end, mid, saturated, index rounding
      '{K_COS,  17'h00000, 32'hffffffff, 32'h00000000, 32'hffffffff, 1'b1, 32'hffffffff},
      '{K_COS,  17'h10000, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b0, 32'h0},
      '{K_COS,  17'h08000, 32'h00001000, 32'h00002000, 32'h00000000, 1'b0, 32'h0},
      '{K_COS,  17'h1ffff, 32'h00000005, 32'hffff0000, 32'h00000000, 1'b0, 32'h0},
      '{K_COS,  17'h00020, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b0, 32'h0},
      '{K_COS,  17'h00010, 32'hffffffff, 32'h00000000, 32'h00000000, 1'b0, 32'h0},
      // bezier: both ends, all ones at the middle, saturated, control only
      '{K_BEZ,  17'h00000, 32'hcafebabe, 32'h11111111, 32'hffffffff, 1'b1, 32'hcafebabe},
      '{K_BEZ,  17'h10000, 32'hcafebabe, 32'h11111111, 32'hffffffff, 1'b1, 32'h11111111},
      '{K_BEZ,  17'h08000, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff},
      '{K_BEZ,  17'h1ffff, 32'h00000000, 32'h76543210, 32'hffffffff, 1'b1, 32'h76543210},
      '{K_BEZ,  17'h05555, 32'h00000000, 32'h00000000, 32'hffffffff, 1'b0, 32'h0},
      '{K_BEZ,  17'h00001, 32'hffffffff, 32'h00000000, 32'h00000000, 1'b0, 32'h0},
      // argb: both ends, ties to even both ways, equal ends, borrow, saturated
      '{K_ARGB, 17'h00000, 32'h80402010, 32'h10204080, 32'hffffffff, 1'b1, 32'h80402010},
      '{K_ARGB, 17'h10000, 32'h80402010, 32'h10204080, 32'h00000000, 1'b1, 32'h10204080},
      '{K_ARGB, 17'h00080, 32'hff00ff00, 32'h00ff00ff, 32'h00000000, 1'b0, 32'h0},
      '{K_ARGB, 17'h00180, 32'hff00ff00, 32'h00ff00ff, 32'h00000000, 1'b0, 32'h0},
      '{K_ARGB, 17'h07777, 32'hdeadbeef, 32'hdeadbeef, 32'h00000000, 1'b1, 32'hdeadbeef},
      '{K_ARGB, 17'h08000, 32'hffffffff, 32'h00000000, 32'h00000000, 1'b0, 32'h0},
      '{K_ARGB, 17'h1ffff, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff},
      '{K_ARGB, 17'h04000, 32'h00ff00ff, 32'hff00ff00, 32'h00000000, 1'b0, 32'h0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, with occasional short gaps between requests
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].start_v,
                   directed_rows[i].end_v, directed_rows[i].ctrl, directed_rows[i].has_want,
                   directed_rows[i].want);
      if ($urandom_range(0, 2) == 0) begin
        idle_burst($urandom_range(1, 11));
      end
    end

    // let the pipe run dry once before the random traffic
    wait_for_results();

    // random traffic: gappy and gap-free stretches take turns, none at the end
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      kind = kvi_pkg::func_e'($urandom_range(0, 3));
      a    = pick_value();
      b    = ($urandom_range(0, 7) == 0) ? a : pick_value();
      send_request(kind, pick_position(), a, b, pick_value(), 1'b0, 32'h0);
      gappy = ((n / 100) % 2 == 0) && (n < RAND_ITEMS - NO_GAP_TAIL);
      if (n % 300 == 299 && n < RAND_ITEMS - NO_GAP_TAIL) begin
        wait_for_results();
      end else if (gappy && $urandom_range(0, 3) == 0) begin
        idle_burst($urandom_range(1, 11));
      end
    end

    // drain, then give stray strobes a chance to show up
    wait_for_results();
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/kvi_pkg.sv
src/kvi_prep.sv
src/kvi_cos_rom.sv
src/kvi_square.sv
src/kvi_blend.sv
src/keyframe_value_interpolator_top.sv
src/kvi_checker.sv
tb/tb_keyframe_value_interpolator_top.sv
